FILE: sv/kal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kal_pkg
// Shared types, token classes and character tables for the keyword-aware lexer.
// ----------------------------------------------------------------------------
package kal_pkg;

    // Token classes
    localparam logic [4:0] CLS_END     = 5'd0;
    localparam logic [4:0] CLS_INT     = 5'd1;
    localparam logic [4:0] CLS_IDENT   = 5'd2;
    localparam logic [4:0] CLS_OP_BASE = 5'd3;
    localparam logic [4:0] CLS_KW_BASE = 5'd15;
    localparam logic [4:0] CLS_UNKNOWN = 5'd21;

    // Input kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam int NUM_KW = 6;

    // One result beat
    typedef struct packed {
        logic [4:0] token_class;
        logic [6:0] lexeme_length;
        logic       lexeme_truncated;
        logic       last;
    } result_t;

    // Results produced for one input item, in order
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

    // Keyword lengths: while if else switch case for
    function automatic logic [2:0] kw_len(input logic [2:0] k);
        logic [2:0] len;
        case (k)
            3'd0:    len = 3'd5;
            3'd1:    len = 3'd2;
            3'd2:    len = 3'd4;
            3'd3:    len = 3'd6;
            3'd4:    len = 3'd4;
            3'd5:    len = 3'd3;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    // Character p of keyword k (zero beyond its end)
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
        logic [47:0] word;
        logic [7:0]  ch;
        case (k)
            3'd0:    word = {"while", 8'h00};
            3'd1:    word = {"if", 32'h0};
            3'd2:    word = {"else", 16'h0};
            3'd3:    word = "switch";
            3'd4:    word = {"case", 16'h0};
            3'd5:    word = {"for", 24'h0};
            default: word = 48'h0;
        endcase
        case (p)
            3'd0:    ch = word[47:40];
            3'd1:    ch = word[39:32];
            3'd2:    ch = word[31:24];
            3'd3:    ch = word[23:16];
            3'd4:    ch = word[15:8];
            3'd5:    ch = word[7:0];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Operator class, or zero when the byte is no operator
    function automatic logic [4:0] op_class(input logic [7:0] c);
        logic [4:0] cls;
        case (c)
            "(":     cls = CLS_OP_BASE + 5'd0;
            ")":     cls = CLS_OP_BASE + 5'd1;
            "+":     cls = CLS_OP_BASE + 5'd2;
            "-":     cls = CLS_OP_BASE + 5'd3;
            "*":     cls = CLS_OP_BASE + 5'd4;
            "/":     cls = CLS_OP_BASE + 5'd5;
            "{":     cls = CLS_OP_BASE + 5'd6;
            "}":     cls = CLS_OP_BASE + 5'd7;
            "<":     cls = CLS_OP_BASE + 5'd8;
            ">":     cls = CLS_OP_BASE + 5'd9;
            "=":     cls = CLS_OP_BASE + 5'd10;
            ";":     cls = CLS_OP_BASE + 5'd11;
            default: cls = 5'd0;
        endcase
        return cls;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

endpackage
`default_nettype wire

FILE: sv/kal_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kal_core
// Token scanner: holds the pending-token state and turns one registered
// input item into zero, one or two result beats combinationally.
// ----------------------------------------------------------------------------
module kal_core
    import kal_pkg::*;
#(
    parameter int LEXEME_MAX = 127
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic       kind_in,
    input  wire logic [7:0] char_in,
    output push_t           push
);

    localparam int CW = $clog2(LEXEME_MAX + 1);

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_IDENT  = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;

    logic [1:0]        mode_reg,  mode_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [NUM_KW-1:0] alive_reg, alive_next;
    logic              ovf_reg,   ovf_next;

    logic              pending;
    logic              letter, digit, space;
    logic              cont;
    logic              has_a, has_b;
    logic [4:0]        op_cls;
    logic [4:0]        close_cls;
    result_t           res_a, res_b;
    logic [NUM_KW-1:0] alive_ext;
    logic [NUM_KW-1:0] alive_start;

    assign pending = (mode_reg == MODE_IDENT) || (mode_reg == MODE_NUMBER);
    assign letter  = is_letter(char_in);
    assign digit   = is_digit(char_in);
    assign space   = is_space(char_in);
    assign op_cls  = op_class(char_in);

    // Keep a pending token growing on letters/digits (digits only for literals)
    assign cont = (kind_in == KIND_CHAR) &&
                  (((mode_reg == MODE_IDENT) && (letter || digit)) ||
                   ((mode_reg == MODE_NUMBER) && digit));

    // Narrow keyword flags by the next character, and seed them on a first letter
    always_comb
    begin
        for (int k = 0; k < NUM_KW; k++)
        begin
            alive_ext[k] = alive_reg[k] &&
                           (count_reg < CW'(kw_len(3'(k)))) &&
                           (kw_char(3'(k), count_reg[2:0]) == char_in);
            alive_start[k] = (kw_char(3'(k), 3'd0) == char_in);
        end
    end

    // Classify the token being closed
    always_comb
    begin
        close_cls = (mode_reg == MODE_IDENT) ? CLS_IDENT : CLS_INT;
        if (mode_reg == MODE_IDENT && !ovf_reg)
        begin
            for (int k = NUM_KW - 1; k >= 0; k--)
            begin
                if (alive_reg[k] && (count_reg == CW'(kw_len(3'(k)))))
                    close_cls = CLS_KW_BASE + 5'(k);
            end
        end
    end

    // Build the closing beat and the character beat
    always_comb
    begin
        has_a = pending && !cont;
        has_b = (kind_in == KIND_END) || (!letter && !digit && !space);

        res_a.token_class      = close_cls;
        res_a.lexeme_length    = 7'(count_reg);
        res_a.lexeme_truncated = ovf_reg;
        res_a.last             = !has_b;

        if (kind_in == KIND_END)
        begin
            res_b.token_class   = CLS_END;
            res_b.lexeme_length = 7'd0;
        end
        else
        begin
            res_b.token_class   = (op_cls != 5'd0) ? op_cls : CLS_UNKNOWN;
            res_b.lexeme_length = 7'd1;
        end
        res_b.lexeme_truncated = 1'b0;
        res_b.last             = 1'b1;

        push.n  = take ? (2'(has_a) + 2'(has_b)) : 2'd0;
        push.r0 = has_a ? res_a : res_b;
        push.r1 = res_b;
    end

    // Next token state
    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        alive_next = alive_reg;
        ovf_next   = ovf_reg;
        if (cont)
        begin
            if (count_reg < CW'(LEXEME_MAX))
            begin
                count_next = count_reg + 1'b1;
                if (mode_reg == MODE_IDENT)
                    alive_next = alive_ext;
            end
            else
            begin
                ovf_next   = 1'b1;
                alive_next = '0;
            end
        end
        else
        begin
            mode_next  = MODE_IDLE;
            count_next = '0;
            alive_next = '0;
            ovf_next   = 1'b0;
            if (kind_in == KIND_CHAR && letter)
            begin
                mode_next  = MODE_IDENT;
                count_next = CW'(1);
                alive_next = alive_start;
            end
            else if (kind_in == KIND_CHAR && digit)
            begin
                mode_next  = MODE_NUMBER;
                count_next = CW'(1);
            end
        end
    end

    // Advance state on each taken item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            count_reg <= '0;
            alive_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            alive_reg <= alive_next;
            ovf_reg   <= ovf_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(LEXEME_MAX))
        else $error("lexeme count beyond limit");

    a_ovf_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == CW'(LEXEME_MAX) && alive_reg == '0))
        else $error("overflow flag without saturated count");

    a_alive_ident: assert property (@(posedge clk) disable iff (!rst_n)
        (alive_reg != '0) |-> (mode_reg == MODE_IDENT))
        else $error("keyword flags set outside an identifier");
`endif

endmodule
`default_nettype wire

FILE: sv/kal_result_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kal_result_fifo
// Four-beat result queue: takes up to two beats per cycle from the scanner
// when it has room; hands one beat per cycle out while out_stall is low.
// ----------------------------------------------------------------------------
module kal_result_fifo
    import kal_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    output logic       room,
    output logic       out_valid,
    input  wire logic  out_stall,
    output result_t    head
);

    localparam int DEPTH = 4;

    result_t    mem_reg [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg,  count_next;
    logic       pop;
    logic [1:0] wr_ptr_p1;

    assign out_valid = (count_reg != 3'd0);
    assign pop       = out_valid && !out_stall;
    assign room      = (count_reg <= 3'd2);
    assign head      = mem_reg[rd_ptr_reg];
    assign wr_ptr_p1 = wr_ptr_reg + 2'd1;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.n;
        rd_ptr_next = rd_ptr_reg + 2'(pop);
        count_next  = count_reg + 3'(push.n) - 3'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store incoming beats in order
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (push.n != 2'd0 && wr_ptr_reg == 2'(i))
                mem_reg[i] <= push.r0;
            if (push.n == 2'd2 && wr_ptr_p1 == 2'(i))
                mem_reg[i] <= push.r1;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> (count_reg <= 3'd2))
        else $error("result queue written without room");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(DEPTH))
        else $error("result queue fill beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 3'd0 || count_reg == 3'(DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with fill count");
`endif

endmodule
`default_nettype wire

FILE: sv/keyword_aware_lexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyword_aware_lexer
// Streaming lexer: one character beat in, token beats out.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with kind and char_byte. Each beat is one
// ASCII byte (kind 0) or an end marker (kind 1).
// Output channel: out_valid/out_stall with token_class, lexeme_length,
// lexeme_truncated and last. An input beat yields zero, one or two output
// beats; last marks the final one of each input beat.
// Path: the input beat that closes a token waits in the input register until
// the scanner takes it; its token beat is registered in the result queue.
// Throughput: one input beat per cycle while the output drains. The output
// port moves one beat per cycle, so input beats that yield two tokens each
// are held back to that rate; the four-beat result queue absorbs the excess.
// Stall: when the receiver stalls, the result queue fills and in_stall rises
// once fewer than two queue entries are free; no beat is lost.
// Reset: clears the pending token, the input register and the result queue;
// the block comes up idle with in_stall low.
// ----------------------------------------------------------------------------
module keyword_aware_lexer
    import kal_pkg::*;
#(
    parameter int LEXEME_MAX = 127
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       kind,
    input  wire logic [7:0] char_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [4:0]      token_class,
    output logic [6:0]      lexeme_length,
    output logic            lexeme_truncated,
    output logic            last
);

    logic       valid_reg;
    logic       kind_reg;
    logic [7:0] char_reg;
    logic       take;
    logic       room;
    push_t      push;
    result_t    head;

    assign take     = valid_reg && room;
    assign in_stall = valid_reg && !room;

    // Hold the input beat until the scanner takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            kind_reg <= kind;
            char_reg <= char_byte;
        end
    end

    kal_core #(
        .LEXEME_MAX (LEXEME_MAX)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .kind_in (kind_reg),
        .char_in (char_reg),
        .push    (push)
    );

    kal_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign token_class      = head.token_class;
    assign lexeme_length    = head.lexeme_length;
    assign lexeme_truncated = head.lexeme_truncated;
    assign last             = head.last;

endmodule
`default_nettype wire
